@@ rtl/core/slpf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpf_pkg
// Shared types and constants of the shortest latency path finder.
// ----------------------------------------------------------------------------
package slpf_pkg;

    localparam int NODES   = 16;
    localparam int NODE_W  = 4;
    localparam int EDGES   = NODES * NODES;
    localparam int EDGE_W  = 2 * NODE_W;
    localparam int DELAY_W = 16;
    localparam int BW_W    = 8;
    localparam int LAT_W   = 32;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_NODE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    typedef struct packed {
        logic wr_node;
        logic wr_edge;
        logic load;
        logic init;
        logic sel_step;
        logic settle;
        logic relax_step;
        logic walk_rd;
        logic walk_upd;
        logic push_from;
        logic emit;
        logic not_found;
    } cmd_t;

    typedef struct packed {
        logic ends_ok;
        logic scan_last;
        logic have;
        logic pick_is_to;
        logic relax_done;
        logic cur_is_from;
        logic len_full;
        logic emit_last;
    } status_t;

endpackage
`default_nettype wire

@@ rtl/core/slpf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slpf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/slpf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpf_ctrl
// Sequencer of the path finder: table writes, search rounds, path walk, output.
// ----------------------------------------------------------------------------
module slpf_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [slpf_pkg::KIND_W-1:0] kind,
    input  wire slpf_pkg::status_t        status,
    output slpf_pkg::cmd_t                cmd,
    output logic                          busy
);
    import slpf_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_SEL      = 4'd2;
    localparam logic [3:0] S_SEL_END  = 4'd3;
    localparam logic [3:0] S_RELAX    = 4'd4;
    localparam logic [3:0] S_WALK     = 4'd5;
    localparam logic [3:0] S_WALK_UPD = 4'd6;
    localparam logic [3:0] S_EMIT     = 4'd7;
    localparam logic [3:0] S_NOTF     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.wr_node = (kind == KIND_NODE);
                    cmd.wr_edge = (kind == KIND_EDGE);
                    if (kind == KIND_QUERY)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (status.ends_ok)
                begin
                    cmd.init   = 1'b1;
                    state_next = S_SEL;
                end
                else
                begin
                    state_next = S_NOTF;
                end
            end
            S_SEL:
            begin
                cmd.sel_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_SEL_END;
                end
            end
            S_SEL_END:
            begin
                if (!status.have)
                begin
                    state_next = S_NOTF;
                end
                else
                begin
                    cmd.settle = 1'b1;
                    state_next = status.pick_is_to ? S_WALK : S_RELAX;
                end
            end
            S_RELAX:
            begin
                cmd.relax_step = 1'b1;
                if (status.relax_done)
                begin
                    state_next = S_SEL;
                end
            end
            S_WALK:
            begin
                if (status.len_full)
                begin
                    state_next = S_NOTF;
                end
                else if (status.cur_is_from)
                begin
                    cmd.push_from = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_WALK_UPD;
                end
            end
            S_WALK_UPD:
            begin
                cmd.walk_upd = 1'b1;
                state_next   = S_WALK;
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_NOTF:
            begin
                cmd.not_found = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/core/slpf_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpf_dp
// Datapath: graph tables, per-query distance scratch, path stack and outputs.
// ----------------------------------------------------------------------------
module slpf_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire slpf_pkg::cmd_t               cmd,
    output slpf_pkg::status_t                 status,
    input  wire logic [slpf_pkg::NODE_W-1:0]  node_a,
    input  wire logic [slpf_pkg::NODE_W-1:0]  node_b,
    input  wire logic                         entry_valid,
    input  wire logic                         is_switch,
    input  wire logic [slpf_pkg::DELAY_W-1:0] delay_value,
    input  wire logic [slpf_pkg::BW_W-1:0]    link_bandwidth,
    output logic                              done,
    output logic                              found,
    output logic [slpf_pkg::NODE_W-1:0]       path_node,
    output logic                              last,
    output logic [slpf_pkg::LAT_W-1:0]        total_latency,
    output logic [slpf_pkg::BW_W-1:0]         min_bandwidth
);
    import slpf_pkg::*;

    localparam int RAM_W = DELAY_W + BW_W;

    logic [NODES-1:0]   present_reg;
    logic [NODES-1:0]   switch_reg;
    logic [DELAY_W-1:0] sdelay_reg [NODES];
    logic [EDGES-1:0]   eprs_reg;

    logic [NODE_W-1:0]  from_reg;
    logic [NODE_W-1:0]  to_reg;
    logic [LAT_W-1:0]   dist_reg [NODES];
    logic [NODE_W-1:0]  pred_reg [NODES];
    logic [NODES-1:0]   settled_reg;
    logic [NODES-1:0]   reached_reg;
    logic [NODE_W-1:0]  idx_reg;
    logic               have_reg;
    logic [NODE_W-1:0]  pick_reg;
    logic [LAT_W-1:0]   pick_dist_reg;
    logic [LAT_W-1:0]   total_reg;
    logic [NODE_W:0]    t_reg;
    logic [NODE_W-1:0]  cur_reg;
    logic [NODE_W:0]    len_reg;
    logic [BW_W-1:0]    bw_reg;
    logic [NODE_W-1:0]  path_reg [NODES];
    logic [NODE_W-1:0]  oidx_reg;

    logic               ram_we;
    logic [EDGE_W-1:0]  ram_waddr;
    logic [RAM_W-1:0]   ram_wdata;
    logic [EDGE_W-1:0]  ram_raddr;
    logic [RAM_W-1:0]   ram_rdata;
    logic [DELAY_W-1:0] ram_lat;
    logic [BW_W-1:0]    ram_bw;

    logic [NODE_W-1:0]  n_w;
    logic               relax_ok;
    logic [LAT_W+1:0]   nd_w;
    logic [LAT_W-1:0]   d_w;
    logic               cand_w;

    assign ram_we    = cmd.wr_edge;
    assign ram_waddr = {node_a, node_b};
    assign ram_wdata = entry_valid ? {delay_value, link_bandwidth} : '0;
    assign ram_raddr = cmd.walk_rd ? {pred_reg[cur_reg], cur_reg}
                                   : {pick_reg, t_reg[NODE_W-1:0]};
    assign ram_lat   = ram_rdata[RAM_W-1:BW_W];
    assign ram_bw    = ram_rdata[BW_W-1:0];

    slpf_ram #(
        .WIDTH (RAM_W),
        .DEPTH (EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign n_w      = NODE_W'(t_reg - 1'b1);
    assign relax_ok = (t_reg != '0) && eprs_reg[{pick_reg, n_w}] && present_reg[n_w]
                      && !settled_reg[n_w];
    assign nd_w     = {2'b00, pick_dist_reg} + {{(LAT_W+2-DELAY_W){1'b0}}, ram_lat}
                      + {{(LAT_W+2-DELAY_W){1'b0}},
                         (switch_reg[n_w] ? sdelay_reg[n_w] : {DELAY_W{1'b0}})};
    assign d_w      = (nd_w[LAT_W+1:LAT_W] != 2'b00) ? {LAT_W{1'b1}} : nd_w[LAT_W-1:0];
    assign cand_w   = reached_reg[idx_reg] && !settled_reg[idx_reg]
                      && (!have_reg || (dist_reg[idx_reg] < pick_dist_reg));

    assign status.ends_ok     = present_reg[from_reg] && present_reg[to_reg];
    assign status.scan_last   = (idx_reg == {NODE_W{1'b1}});
    assign status.have        = have_reg;
    assign status.pick_is_to  = (pick_reg == to_reg);
    assign status.relax_done  = (t_reg == 5'(NODES));
    assign status.cur_is_from = (cur_reg == from_reg);
    assign status.len_full    = len_reg[NODE_W];
    assign status.emit_last   = (oidx_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            switch_reg  <= '0;
            eprs_reg    <= '0;
            for (int i = 0; i < NODES; i++)
            begin
                sdelay_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.wr_node)
            begin
                present_reg[node_a] <= entry_valid;
                switch_reg[node_a]  <= entry_valid & is_switch;
                sdelay_reg[node_a]  <= entry_valid ? delay_value : '0;
            end
            if (cmd.wr_edge)
            begin
                eprs_reg[{node_a, node_b}] <= entry_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            from_reg <= node_a;
            to_reg   <= node_b;
        end
        if (cmd.init)
        begin
            settled_reg        <= '0;
            reached_reg        <= NODES'(1) << from_reg;
            dist_reg[from_reg] <= '0;
            idx_reg            <= '0;
            have_reg           <= 1'b0;
            len_reg            <= '0;
            bw_reg             <= {BW_W{1'b1}};
            cur_reg            <= to_reg;
        end
        if (cmd.sel_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (cand_w)
            begin
                have_reg      <= 1'b1;
                pick_reg      <= idx_reg;
                pick_dist_reg <= dist_reg[idx_reg];
            end
        end
        if (cmd.settle)
        begin
            settled_reg[pick_reg] <= 1'b1;
            idx_reg               <= '0;
            have_reg              <= 1'b0;
            t_reg                 <= '0;
            total_reg             <= pick_dist_reg;
        end
        if (cmd.relax_step)
        begin
            t_reg <= t_reg + 1'b1;
            if (relax_ok && (!reached_reg[n_w] || (d_w < dist_reg[n_w])))
            begin
                reached_reg[n_w] <= 1'b1;
                dist_reg[n_w]    <= d_w;
                pred_reg[n_w]    <= pick_reg;
            end
        end
        if (cmd.walk_rd)
        begin
            path_reg[len_reg[NODE_W-1:0]] <= cur_reg;
            len_reg                       <= len_reg + 1'b1;
        end
        if (cmd.walk_upd)
        begin
            if (ram_bw < bw_reg)
            begin
                bw_reg <= ram_bw;
            end
            cur_reg <= pred_reg[cur_reg];
        end
        if (cmd.push_from)
        begin
            path_reg[len_reg[NODE_W-1:0]] <= from_reg;
            oidx_reg                      <= len_reg[NODE_W-1:0];
        end
        if (cmd.emit)
        begin
            oidx_reg <= oidx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= cmd.emit | cmd.not_found;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            found         <= 1'b1;
            path_node     <= path_reg[oidx_reg];
            last          <= (oidx_reg == '0);
            total_latency <= total_reg;
            min_bandwidth <= bw_reg;
        end
        else if (cmd.not_found)
        begin
            found         <= 1'b0;
            path_node     <= '0;
            last          <= 1'b1;
            total_latency <= '0;
            min_bandwidth <= '0;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/shortest_latency_path_finder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shortest_latency_path_finder
// Directed graph store with a sequential Dijkstra path search.
// A query runs a check step, then for each settled node a select scan over all nodes,
// a settle and a neighbor pass over the edge RAM read port (skipped for the end node),
// then a read and an update step per path hop plus a step that pushes the start node,
// and emits one result per cycle, each registered onto the ports in the following cycle.
// One query at a time; busy drops in the cycle the last result is on the ports.
// The receiver cannot stall results. Reset clears the node table and edge present bits.
// ----------------------------------------------------------------------------
module shortest_latency_path_finder (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [slpf_pkg::KIND_W-1:0]  kind,
    input  wire logic [slpf_pkg::NODE_W-1:0]  node_a,
    input  wire logic [slpf_pkg::NODE_W-1:0]  node_b,
    input  wire logic                         entry_valid,
    input  wire logic                         is_switch,
    input  wire logic [slpf_pkg::DELAY_W-1:0] delay_value,
    input  wire logic [slpf_pkg::BW_W-1:0]    link_bandwidth,
    output logic                              done,
    output logic                              found,
    output logic [slpf_pkg::NODE_W-1:0]       path_node,
    output logic                              last,
    output logic [slpf_pkg::LAT_W-1:0]        total_latency,
    output logic [slpf_pkg::BW_W-1:0]         min_bandwidth
);
    import slpf_pkg::*;

    cmd_t    cmd;
    status_t status;

    slpf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    slpf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .node_a         (node_a),
        .node_b         (node_b),
        .entry_valid    (entry_valid),
        .is_switch      (is_switch),
        .delay_value    (delay_value),
        .link_bandwidth (link_bandwidth),
        .done           (done),
        .found          (found),
        .path_node      (path_node),
        .last           (last),
        .total_latency  (total_latency),
        .min_bandwidth  (min_bandwidth)
    );
endmodule
`default_nettype wire

@@ tb/shortest_latency_path_finder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_latency_path_finder_tb
// Drives node writes, edge writes and path queries into the path finder,
// predicts path hops from a local copy of the graph or a typed expectation, and compares each
// result strobe field by field. A directed table comes first, then random
// graph traffic under several sender idle patterns.
// ----------------------------------------------------------------------------
module shortest_latency_path_finder_tb;
    import slpf_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 250;
    localparam int DRAIN_CYCLES = 700;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [NODE_W-1:0]  a;
        logic [NODE_W-1:0]  b;
        logic               ev;
        logic               sw;
        logic [DELAY_W-1:0] dly;
        logic [BW_W-1:0]    bw;
        bit                 typed;
        logic               t_found;
        logic [NODE_W-1:0]  t_node;
        logic [LAT_W-1:0]   t_lat;
        logic [BW_W-1:0]    t_bw;
    } step_t;

    typedef struct {
        logic               found;
        logic [NODE_W-1:0]  node;
        logic               last;
        logic [LAT_W-1:0]   lat;
        logic [BW_W-1:0]    bw;
    } hop_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [KIND_W-1:0]   kind;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic                entry_valid;
    logic                is_switch;
    logic [DELAY_W-1:0]  delay_value;
    logic [BW_W-1:0]     link_bandwidth;
    logic                done;
    logic                found;
    logic [NODE_W-1:0]   path_node;
    logic                last;
    logic [LAT_W-1:0]    total_latency;
    logic [BW_W-1:0]     min_bandwidth;

    logic                g_node_on [NODES];
    logic                g_node_sw [NODES];
    logic [DELAY_W-1:0]  g_node_dly[NODES];
    logic                g_edge_on [NODES][NODES];
    logic [DELAY_W-1:0]  g_edge_lat[NODES][NODES];
    logic [BW_W-1:0]     g_edge_bw [NODES][NODES];

    hop_t  hop_q[$];
    step_t plan_q[$];
    int    mismatches;
    int    idle_pct;

    shortest_latency_path_finder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .node_a         (node_a),
        .node_b         (node_b),
        .entry_valid    (entry_valid),
        .is_switch      (is_switch),
        .delay_value    (delay_value),
        .link_bandwidth (link_bandwidth),
        .done           (done),
        .found          (found),
        .path_node      (path_node),
        .last           (last),
        .total_latency  (total_latency),
        .min_bandwidth  (min_bandwidth)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic step_t row(logic [KIND_W-1:0] k, logic [NODE_W-1:0] a,
                                  logic [NODE_W-1:0] b, logic ev, logic sw,
                                  logic [DELAY_W-1:0] dly, logic [BW_W-1:0] bw);
        step_t s;
        s.kind = k; s.a = a; s.b = b; s.ev = ev; s.sw = sw; s.dly = dly; s.bw = bw;
        s.typed = 1'b0; s.t_found = 1'b0; s.t_node = '0; s.t_lat = '0; s.t_bw = '0;
        return s;
    endfunction

    function automatic step_t typed_query(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                                          logic f, logic [NODE_W-1:0] n,
                                          logic [BW_W-1:0] bw);
        step_t s;
        s = row(KIND_QUERY, a, b, 1'b0, 1'b0, '0, '0);
        s.typed = 1'b1; s.t_found = f; s.t_node = n; s.t_lat = '0; s.t_bw = bw;
        return s;
    endfunction

    function automatic void add_plan(step_t s);
        plan_q = {plan_q, s};
    endfunction

    function automatic void push_hop(logic f, logic [NODE_W-1:0] n, logic l,
                                     logic [LAT_W-1:0] lat, logic [BW_W-1:0] bw);
        hop_t h;
        h.found = f; h.node = n; h.last = l; h.lat = lat; h.bw = bw;
        hop_q = {hop_q, h};
    endfunction

    function automatic void find_route(logic [NODE_W-1:0] from, logic [NODE_W-1:0] to);
        logic [LAT_W-1:0]   best[NODES];
        logic [NODE_W-1:0]  pred[NODES];
        bit                 fixed[NODES];
        bit                 seen[NODES];
        logic [NODE_W-1:0]  route[NODES];
        logic [LAT_W:0]     nd;
        logic [LAT_W-1:0]   d;
        logic [NODE_W-1:0]  cur;
        logic [BW_W-1:0]    bw;
        bit                 have;
        int                 pick;
        int                 len;
        if (!g_node_on[from] || !g_node_on[to]) begin
            push_hop(1'b0, '0, 1'b1, '0, '0);
            return;
        end
        for (int i = 0; i < NODES; i++) begin
            best[i] = '0; pred[i] = '0; fixed[i] = 0; seen[i] = 0;
        end
        seen[from] = 1;
        while (1) begin
            have = 0;
            pick = 0;
            for (int i = 0; i < NODES; i++)
                if (seen[i] && !fixed[i] && (!have || best[i] < best[pick])) begin
                    have = 1;
                    pick = i;
                end
            if (!have)
                break;
            fixed[pick] = 1;
            if (pick == to)
                break;
            for (int n = 0; n < NODES; n++) begin
                if (!g_edge_on[pick][n] || !g_node_on[n] || fixed[n])
                    continue;
                nd = {1'b0, best[pick]} + g_edge_lat[pick][n];
                if (g_node_sw[n])
                    nd += g_node_dly[n];
                d = nd[LAT_W] ? '1 : nd[LAT_W-1:0];
                if (!seen[n] || d < best[n]) begin
                    seen[n] = 1;
                    best[n] = d;
                    pred[n] = NODE_W'(pick);
                end
            end
        end
        if (!seen[to]) begin
            push_hop(1'b0, '0, 1'b1, '0, '0);
            return;
        end
        len = 0;
        cur = to;
        while (cur != from && len < NODES) begin
            route[len++] = cur;
            cur = pred[cur];
        end
        if (cur != from || len >= NODES) begin
            push_hop(1'b0, '0, 1'b1, '0, '0);
            return;
        end
        route[len++] = from;
        bw = '1;
        for (int i = 0; i + 1 < len; i++)
            if (g_edge_bw[route[i+1]][route[i]] < bw)
                bw = g_edge_bw[route[i+1]][route[i]];
        for (int k = 0; k < len; k++)
            push_hop(1'b1, route[len-1-k], k + 1 == len, best[to], bw);
    endfunction

    function automatic void apply_step(step_t s);
        case (s.kind)
            KIND_NODE: begin
                g_node_on[s.a]  = s.ev;
                g_node_sw[s.a]  = s.ev ? s.sw : 1'b0;
                g_node_dly[s.a] = s.ev ? s.dly : '0;
            end
            KIND_EDGE: begin
                g_edge_on[s.a][s.b]  = s.ev;
                g_edge_lat[s.a][s.b] = s.ev ? s.dly : '0;
                g_edge_bw[s.a][s.b]  = s.ev ? s.bw : '0;
            end
            KIND_QUERY: begin
                if (s.typed) begin
                    push_hop(s.t_found, s.t_node, 1'b1, s.t_lat, s.t_bw);
                end else begin
                    find_route(s.a, s.b);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic step_t random_step();
        step_t s;
        int    r;
        logic [DELAY_W-1:0] dly;
        r = $urandom_range(99);
        dly = ($urandom_range(3) == 0) ? DELAY_W'($urandom) : DELAY_W'($urandom_range(40));
        if (r < 25)
            s = row(KIND_NODE, NODE_W'($urandom), '0, $urandom_range(99) < 88,
                    $urandom_range(1), dly, BW_W'($urandom));
        else if (r < 62)
            s = row(KIND_EDGE, NODE_W'($urandom), NODE_W'($urandom),
                    $urandom_range(99) < 85, $urandom_range(1), dly, BW_W'($urandom));
        else if (r < 96)
            s = row(KIND_QUERY, NODE_W'($urandom), NODE_W'($urandom),
                    $urandom_range(1), $urandom_range(1), DELAY_W'($urandom),
                    BW_W'($urandom));
        else
            s = row(KIND_UNUSED, NODE_W'($urandom), NODE_W'($urandom),
                    $urandom_range(1), $urandom_range(1), DELAY_W'($urandom),
                    BW_W'($urandom));
        return s;
    endfunction

    task automatic send_step(step_t s);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        kind           <= s.kind;
        node_a         <= s.a;
        node_b         <= s.b;
        entry_valid    <= s.ev;
        is_switch      <= s.sw;
        delay_value    <= s.dly;
        link_bandwidth <= s.bw;
        do @(posedge clk); while (busy !== 1'b0 || start !== 1'b1);
        apply_step(s);
    endtask

    always @(posedge clk) begin
        if (rst_n && done === 1'b1) begin
            if (hop_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: node %0d lat %0d", path_node, total_latency);
            end else begin
                hop_t e;
                e = hop_q.pop_front();
                if (found !== e.found || path_node !== e.node || last !== e.last ||
                    total_latency !== e.lat || min_bandwidth !== e.bw) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: exp f%0d n%0d l%0d lat%0d bw%0d, ",
                               e.found, e.node, e.last, e.lat, e.bw);
                        $display("got f%0d n%0d l%0d lat%0d bw%0d",
                                 found, path_node, last, total_latency, min_bandwidth);
                    end
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        mismatches     = 0;
        idle_pct       = 0;
        rst_n          = 1'b0;
        start          = 1'b0;
        kind           = KIND_NODE;
        node_a         = '0;
        node_b         = '0;
        entry_valid    = 1'b0;
        is_switch      = 1'b0;
        delay_value    = '0;
        link_bandwidth = '0;
        for (int i = 0; i < NODES; i++) begin
            g_node_on[i] = 0; g_node_sw[i] = 0; g_node_dly[i] = '0;
            for (int j = 0; j < NODES; j++) begin
                g_edge_on[i][j] = 0; g_edge_lat[i][j] = '0; g_edge_bw[i][j] = '0;
            end
        end

        add_plan(typed_query(4'd0, 4'd0, 1'b0, 4'd0, 8'd0));
        add_plan(row(KIND_UNUSED, 4'd15, 4'd15, 1'b1, 1'b1, 16'hFFFF, 8'hFF));
        add_plan(row(KIND_NODE, 4'd0, 4'd0, 1'b1, 1'b0, 16'd0, 8'd0));
        add_plan(typed_query(4'd0, 4'd0, 1'b1, 4'd0, 8'd255));
        add_plan(row(KIND_NODE, 4'd15, 4'd0, 1'b1, 1'b1, 16'hFFFF, 8'd0));
        add_plan(row(KIND_EDGE, 4'd0, 4'd15, 1'b1, 1'b0, 16'hFFFF, 8'hFF));
        add_plan(row(KIND_QUERY, 4'd0, 4'd15, 1'b0, 1'b0, 16'd0, 8'd0));
        add_plan(typed_query(4'd15, 4'd0, 1'b0, 4'd0, 8'd0));
        add_plan(row(KIND_NODE, 4'd1, 4'd0, 1'b1, 1'b1, 16'd5, 8'd0));
        add_plan(row(KIND_EDGE, 4'd0, 4'd1, 1'b1, 1'b0, 16'd0, 8'd0));
        add_plan(row(KIND_EDGE, 4'd1, 4'd15, 1'b1, 1'b0, 16'd3, 8'd200));
        add_plan(row(KIND_QUERY, 4'd0, 4'd15, 1'b0, 1'b0, 16'd0, 8'd0));
        add_plan(row(KIND_NODE, 4'd3, 4'd0, 1'b1, 1'b0, 16'd0, 8'd0));
        add_plan(row(KIND_EDGE, 4'd0, 4'd3, 1'b1, 1'b0, 16'd5, 8'd77));
        add_plan(row(KIND_EDGE, 4'd3, 4'd15, 1'b1, 1'b0, 16'h0003, 8'd90));
        add_plan(row(KIND_QUERY, 4'd0, 4'd15, 1'b0, 1'b0, 16'd0, 8'd0));
        add_plan(row(KIND_EDGE, 4'd0, 4'd2, 1'b1, 1'b0, 16'd1, 8'd1));
        add_plan(typed_query(4'd0, 4'd2, 1'b0, 4'd0, 8'd0));
        add_plan(row(KIND_NODE, 4'd1, 4'd0, 1'b0, 1'b1, 16'hFFFF, 8'd0));
        add_plan(row(KIND_QUERY, 4'd0, 4'd15, 1'b0, 1'b0, 16'd0, 8'd0));
        add_plan(row(KIND_EDGE, 4'd0, 4'd15, 1'b0, 1'b1, 16'hFFFF, 8'hFF));
        add_plan(row(KIND_QUERY, 4'd0, 4'd15, 1'b1, 1'b1, 16'hFFFF, 8'hFF));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_q[i])
            send_step(plan_q[i]);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case (i * 4 / RANDOM_ITEMS)
                0: idle_pct = 0;
                1: idle_pct = 66;
                2: idle_pct = 0;
                default: idle_pct = 8;
            endcase
            send_step(random_step());
        end
        start <= 1'b0;

        while (hop_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && hop_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
